// ----- rtl/core/scc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Types, constants and codes shared by the sprite cull and clip block.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int NUM_TYPES      = 256;
    localparam int TYPE_AW        = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int RESUME_W       = 16;
    localparam logic [RESUME_W-1:0] RESUME_BACKOFF = RESUME_W'(100);

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROCESS = 1'b1;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_CULLED = 2'd1,
        ST_DRAWN  = 2'd2,
        ST_BEYOND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_WINDOW_X      = 3'd0,
        CFG_WINDOW_WIDTH  = 3'd1,
        CFG_WINDOW_Y      = 3'd2,
        CFG_WINDOW_HEIGHT = 3'd3,
        CFG_TARGET_X      = 3'd4,
        CFG_TARGET_Y      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0] w;
        logic [9:0] h;
        logic [9:0] sx;
        logic [9:0] sy;
    } t_type_entry;

    typedef struct packed {
        logic [14:0] wx;
        logic [11:0] ww;
        logic [14:0] wy;
        logic [11:0] wh;
        logic [11:0] tx;
        logic [11:0] ty;
    } t_window;

    localparam t_window WINDOW_RESET = '{
        wx: 15'd0, ww: 12'd640, wy: 15'd0, wh: 12'd480, tx: 12'd0, ty: 12'd0
    };

    typedef struct packed {
        logic [11:0] src_left;
        logic [11:0] src_top;
        logic [11:0] src_right;
        logic [11:0] src_bottom;
        logic [12:0] dest_x;
        logic [12:0] dest_y;
    } t_rect;

    typedef struct packed {
        logic  beyond;
        logic  culled;
        t_rect rect;
    } t_clip_res;

endpackage

// ----- rtl/core/scc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_if
// Request channels of the sprite cull and clip block: items, results, config.
// ----------------------------------------------------------------------------
interface scc_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  type_slot;
    logic [9:0]  type_width;
    logic [9:0]  type_height;
    logic [9:0]  type_sheet_x;
    logic [9:0]  type_sheet_y;
    logic [14:0] sprite_x;
    logic [14:0] sprite_y;
    logic [7:0]  sprite_kind;
    logic [15:0] sprite_number;
    logic        scan_start;

    modport source (
        output valid, command, type_slot, type_width, type_height, type_sheet_x,
               type_sheet_y, sprite_x, sprite_y, sprite_kind, sprite_number,
               scan_start,
        input  ready
    );
    modport sink (
        input  valid, command, type_slot, type_width, type_height, type_sheet_x,
               type_sheet_y, sprite_x, sprite_y, sprite_kind, sprite_number,
               scan_start,
        output ready
    );
endinterface

interface scc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] src_left;
    logic [11:0] src_top;
    logic [11:0] src_right;
    logic [11:0] src_bottom;
    logic [12:0] dest_x;
    logic [12:0] dest_y;
    logic [15:0] resume_index;

    modport source (
        output valid, status, src_left, src_top, src_right, src_bottom, dest_x,
               dest_y, resume_index,
        input  ready
    );
    modport sink (
        input  valid, status, src_left, src_top, src_right, src_bottom, dest_x,
               dest_y, resume_index,
        output ready
    );
endinterface

interface scc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [14:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/scc_clip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_clip
// Cull and beyond tests and per-axis clipping of one sprite against the window.
// ----------------------------------------------------------------------------
module scc_clip
    import scc_pkg::*;
(
    input  t_window     i_win,
    input  logic [14:0] i_x,
    input  logic [14:0] i_y,
    input  t_type_entry i_entry,
    output t_clip_res   o_res
);

    typedef struct packed {
        logic [11:0] lo;
        logic [11:0] hi;
        logic [12:0] dst;
    } t_axis;

    function automatic t_axis clip_axis(
        input logic [14:0] pos,
        input logic [9:0]  size,
        input logic [9:0]  origin,
        input logic [14:0] ws,
        input logic [11:0] wl,
        input logic [11:0] tgt
    );
        logic signed [18:0] p, s, o, a, l, t;
        logic signed [18:0] endp, wend, len, lo, hi, dst;
        t_axis r;
        p    = 19'(pos);
        s    = 19'(size);
        o    = 19'(origin);
        a    = 19'(ws);
        l    = 19'(wl);
        t    = 19'(tgt);
        endp = p + s;
        wend = a + l;
        if (p < a) begin
            lo  = a - p + o;
            dst = t;
            len = (endp > wend) ? l : endp - a;
        end else begin
            lo  = o;
            dst = t + p - a;
            len = (endp > wend) ? wend - p : s;
        end
        hi    = lo + len;
        r.lo  = lo[11:0];
        r.hi  = hi[11:0];
        r.dst = dst[12:0];
        return r;
    endfunction

    t_axis w_ax_x;
    t_axis w_ax_y;

    always_comb begin
        w_ax_x = clip_axis(i_x, i_entry.w, i_entry.sx, i_win.wx, i_win.ww, i_win.tx);
        w_ax_y = clip_axis(i_y, i_entry.h, i_entry.sy, i_win.wy, i_win.wh, i_win.ty);

        o_res.beyond = 16'(i_y) >= (16'(i_win.wy) + 16'(i_win.wh));
        o_res.culled = ((16'(i_y) + 16'(i_entry.h)) < 16'(i_win.wy))
                    || ((16'(i_x) + 16'(i_entry.w)) < 16'(i_win.wx))
                    || (16'(i_x) > (16'(i_win.wx) + 16'(i_win.ww)));

        o_res.rect.src_left   = w_ax_x.lo;
        o_res.rect.src_right  = w_ax_x.hi;
        o_res.rect.dest_x     = w_ax_x.dst;
        o_res.rect.src_top    = w_ax_y.lo;
        o_res.rect.src_bottom = w_ax_y.hi;
        o_res.rect.dest_y     = w_ax_y.dst;
    end

endmodule

// ----- rtl/core/sprite_cull_and_clip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_cull_and_clip
// Culls and clips y-sorted sprite items against a drawing window.
// ----------------------------------------------------------------------------
// i_item carries load requests (write one type table entry) and process
// requests (one sprite item); every request gives exactly one result on
// o_result, in order. i_cfg writes the window and target registers and is
// always ready; write it only while no request is in flight.
// After item acceptance the result passes the read stage and the output
// register: the type table is a synchronous memory read at acceptance, and
// the cull and clip logic works on the read data and lands in the output
// register.
// Throughput is one request per cycle while o_result does not stall.
// A load written at one edge is seen by a process request accepted at any
// later edge, so back-to-back load then process needs no interlock.
// When the receiver stalls, the output register holds its result, the
// middle stage fills, and only then does i_item drop ready.
// Reset clears the pipeline, the scan flag and the resume index and loads
// the default window; the type table is not cleared and must be loaded
// before its entries are used.
// ----------------------------------------------------------------------------
module sprite_cull_and_clip
    import scc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    scc_item_if.sink          i_item,
    scc_result_if.source      o_result,
    scc_cfg_if.sink           i_cfg
);

    t_window            r_win;
    t_type_entry        r_type_mem [NUM_TYPES];
    t_type_entry        r_rd;

    logic               r_s1_valid;
    logic               r_s1_cmd;
    logic               r_s1_kind_ok;
    logic               r_s1_start;
    logic [14:0]        r_s1_x;
    logic [14:0]        r_s1_y;
    logic [15:0]        r_s1_num;

    logic               r_out_valid;
    t_status            r_out_status;
    t_rect              r_out_rect;
    logic [RESUME_W-1:0] r_out_resume;

    logic               r_found;
    logic [RESUME_W-1:0] r_resume;

    logic               w_acc;
    logic               w_s1_adv;
    logic               w_slot_ok;
    logic               w_kind_ok;
    t_type_entry        w_entry;
    t_clip_res          w_clip;
    t_status            n_status;
    logic               n_found;
    logic [RESUME_W-1:0] n_resume;

    assign w_s1_adv     = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_s1_valid || w_s1_adv;
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_slot_ok    = 32'(i_item.type_slot) < NUM_TYPES;
    assign w_kind_ok    = 32'(i_item.sprite_kind) < NUM_TYPES;
    assign i_cfg.ready  = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WINDOW_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WINDOW_X:      r_win.wx <= i_cfg.data;
                CFG_WINDOW_WIDTH:  r_win.ww <= i_cfg.data[11:0];
                CFG_WINDOW_Y:      r_win.wy <= i_cfg.data;
                CFG_WINDOW_HEIGHT: r_win.wh <= i_cfg.data[11:0];
                CFG_TARGET_X:      r_win.tx <= i_cfg.data[11:0];
                CFG_TARGET_Y:      r_win.ty <= i_cfg.data[11:0];
                default: ;
            endcase
        end
    end

    // type table
    always_ff @(posedge i_clk) begin
        if (w_acc && i_item.command == CMD_LOAD && w_slot_ok) begin
            r_type_mem[TYPE_AW'(i_item.type_slot)] <= '{
                w:  i_item.type_width,
                h:  i_item.type_height,
                sx: i_item.type_sheet_x,
                sy: i_item.type_sheet_y
            };
        end
        if (w_acc && i_item.command == CMD_PROCESS) begin
            r_rd <= r_type_mem[TYPE_AW'(i_item.sprite_kind)];
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_cmd     <= i_item.command;
            r_s1_kind_ok <= w_kind_ok;
            r_s1_start   <= i_item.scan_start;
            r_s1_x       <= i_item.sprite_x;
            r_s1_y       <= i_item.sprite_y;
            r_s1_num     <= i_item.sprite_number;
        end
    end

    assign w_entry = r_s1_kind_ok ? r_rd : '0;

    scc_clip u_clip (
        .i_win   (r_win),
        .i_x     (r_s1_x),
        .i_y     (r_s1_y),
        .i_entry (w_entry),
        .o_res   (w_clip)
    );

    always_comb begin
        n_found  = r_found;
        n_resume = r_resume;
        if (r_s1_cmd == CMD_LOAD) begin
            n_status = ST_LOADED;
        end else begin
            if (r_s1_start) begin
                n_found = 1'b0;
            end
            priority if (w_clip.beyond) begin
                n_status = ST_BEYOND;
            end else if (w_clip.culled) begin
                n_status = ST_CULLED;
            end else begin
                n_status = ST_DRAWN;
                if (!n_found) begin
                    n_resume = (r_s1_num >= RESUME_BACKOFF) ?
                               RESUME_W'(r_s1_num - RESUME_BACKOFF) : '0;
                    n_found  = 1'b1;
                end
            end
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_resume <= '0;
        end else if (r_s1_valid && w_s1_adv) begin
            r_found  <= n_found;
            r_resume <= n_resume;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_s1_adv) begin
            r_out_status <= n_status;
            r_out_rect   <= (n_status == ST_DRAWN) ? w_clip.rect : '0;
            r_out_resume <= n_resume;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out_status;
    assign o_result.src_left     = r_out_rect.src_left;
    assign o_result.src_top      = r_out_rect.src_top;
    assign o_result.src_right    = r_out_rect.src_right;
    assign o_result.src_bottom   = r_out_rect.src_bottom;
    assign o_result.dest_x       = r_out_rect.dest_x;
    assign o_result.dest_y       = r_out_rect.dest_y;
    assign o_result.resume_index = r_out_resume;

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_s1_valid)
        else $error("accepted request did not enter the read stage");

    a_resume_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_resume == r_resume))
        else $error("resume index in result differs from scan state");

    a_drawn_sets_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_DRAWN) |-> r_found)
        else $error("drawn result without scan flag");

    a_rect_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_DRAWN) |-> (r_out_rect == '0))
        else $error("rectangle not cleared for a result that is not drawn");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> r_s1_valid)
        else $error("stalled request lost from the read stage");

endmodule
